@@ rtl/smsc_pkg.sv @@
`default_nettype none

package smsc_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int CFG_W      = 31;
   localparam int HALF_SHIFT = 31;
   localparam int PROD_W     = DATA_W + 1 + CFG_W;
   localparam int SUM_W      = DATA_W + 2;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CFG_W-1:0] INV_PERIOD_RST    = CFG_W'(65536000);
   localparam logic [CFG_W-1:0] HALF_PERIOD_RST   = CFG_W'(1073742);
   localparam logic [CFG_W-1:0] SURFACE_SLOPE_RST = CFG_W'(65536);
   localparam logic [CFG_W-1:0] OVERALL_GAIN_RST  = CFG_W'(65536);

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SUM_MAX =
      {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN =
      {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_PERIOD    = 3'd0,
      CSR_HALF_PERIOD   = 3'd1,
      CSR_SURFACE_SLOPE = 3'd2,
      CSR_SWITCH_GAIN   = 3'd3,
      CSR_EXP_GAIN      = 3'd4,
      CSR_OVERALL_GAIN  = 3'd5,
      CSR_OUT_MAX       = 3'd6,
      CSR_OUT_MIN       = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [CFG_W-1:0]         inv_period;
      logic [CFG_W-1:0]         half_period;
      logic [CFG_W-1:0]         surface_slope;
      logic [CFG_W-1:0]         switch_gain;
      logic [CFG_W-1:0]         exp_gain;
      logic [CFG_W-1:0]         overall_gain;
      logic signed [DATA_W-1:0] out_max;
      logic signed [DATA_W-1:0] out_min;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_DE,
      OP_CE,
      OP_CDE,
      OP_QS,
      OP_G,
      OP_H
   } op_type;

   typedef struct packed {
      logic   load;
      logic   mul;
      logic   wr;
      logic   commit;
      logic   clear;
      op_type op;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DE_M,
      ST_DE_W,
      ST_CE_M,
      ST_CE_W,
      ST_CDE_M,
      ST_CDE_W,
      ST_QS_M,
      ST_QS_W,
      ST_G_M,
      ST_G_W,
      ST_H_M,
      ST_H_W,
      ST_CLEAR
   } state_type;

   function automatic logic signed [SUM_W-1:0] sext_sum(input logic signed [DATA_W-1:0] v);
      return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > SUM_MAX) begin
         r = DATA_MAX;
      end else if (x < SUM_MIN) begin
         r = DATA_MIN;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   // Product magnitude is truncated towards zero, then limited so that the
   // signed result stays inside the data range.
   function automatic logic signed [DATA_W-1:0] scale_product(
      input logic [PROD_W-1:0] prod,
      input logic              neg,
      input logic              half
   );
      logic [PROD_W-1:0] shifted;
      logic [DATA_W-1:0] limit;
      logic [DATA_W-1:0] mag;
      shifted = half ? (prod >> HALF_SHIFT) : (prod >> FRAC_BITS);
      limit   = DATA_MAX + {{(DATA_W-1){1'b0}}, neg};
      if (shifted > {{(PROD_W-DATA_W){1'b0}}, limit}) begin
         mag = limit;
      end else begin
         mag = shifted[DATA_W-1:0];
      end
      return neg ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

@@ rtl/smsc_intf.sv @@
`default_nettype none

interface smsc_req_if;
   import smsc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic signed [DATA_W-1:0] reference;
   logic signed [DATA_W-1:0] feedback;
   modport source (output valid, action, reference, feedback, input ready);
   modport sink (input valid, action, reference, feedback, output ready);
endinterface

interface smsc_rsp_if;
   import smsc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] drive_out;
   logic                     frozen_out;
   modport source (output valid, drive_out, frozen_out, input ready);
   modport sink (input valid, drive_out, frozen_out, output ready);
endinterface

interface smsc_csr_if;
   import smsc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/smsc_regs.sv @@
`default_nettype none

module smsc_regs (
   input  wire logic     clock,
   input  wire logic     reset,
   smsc_csr_if.sink      csr_ch,
   output smsc_pkg::cfg_type cfg
);
   import smsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_INV_PERIOD:    cfg_in.inv_period    = csr_ch.data[CFG_W-1:0];
            CSR_HALF_PERIOD:   cfg_in.half_period   = csr_ch.data[CFG_W-1:0];
            CSR_SURFACE_SLOPE: cfg_in.surface_slope = csr_ch.data[CFG_W-1:0];
            CSR_SWITCH_GAIN:   cfg_in.switch_gain   = csr_ch.data[CFG_W-1:0];
            CSR_EXP_GAIN:      cfg_in.exp_gain      = csr_ch.data[CFG_W-1:0];
            CSR_OVERALL_GAIN:  cfg_in.overall_gain  = csr_ch.data[CFG_W-1:0];
            CSR_OUT_MAX:       cfg_in.out_max       = csr_ch.data;
            CSR_OUT_MIN:       cfg_in.out_min       = csr_ch.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_period    <= INV_PERIOD_RST;
         cfg_ff.half_period   <= HALF_PERIOD_RST;
         cfg_ff.surface_slope <= SURFACE_SLOPE_RST;
         cfg_ff.switch_gain   <= '0;
         cfg_ff.exp_gain      <= '0;
         cfg_ff.overall_gain  <= OVERALL_GAIN_RST;
         cfg_ff.out_max       <= DATA_MAX;
         cfg_ff.out_min       <= DATA_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/smsc_ctrl.sv @@
`default_nettype none

module smsc_ctrl (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   input  wire logic      req_action,
   output logic           req_ready,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output smsc_pkg::cmd_type cmd
);
   import smsc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      req_take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_action ? ST_CLEAR : ST_DE_M;
            end
         end
         ST_DE_M:  state_in = ST_DE_W;
         ST_DE_W:  state_in = ST_CE_M;
         ST_CE_M:  state_in = ST_CE_W;
         ST_CE_W:  state_in = ST_CDE_M;
         ST_CDE_M: state_in = ST_CDE_W;
         ST_CDE_W: state_in = ST_QS_M;
         ST_QS_M:  state_in = ST_QS_W;
         ST_QS_W:  state_in = ST_G_M;
         ST_G_M:   state_in = ST_G_W;
         ST_G_W:   state_in = ST_H_M;
         ST_H_M:   state_in = ST_H_W;
         ST_H_W, ST_CLEAR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.op   = OP_DE;
      unique case (state_ff)
         ST_IDLE:  cmd.load = req_take && !req_action;
         ST_DE_M:  begin cmd.mul = 1'b1; cmd.op = OP_DE;  end
         ST_DE_W:  begin cmd.wr  = 1'b1; cmd.op = OP_DE;  end
         ST_CE_M:  begin cmd.mul = 1'b1; cmd.op = OP_CE;  end
         ST_CE_W:  begin cmd.wr  = 1'b1; cmd.op = OP_CE;  end
         ST_CDE_M: begin cmd.mul = 1'b1; cmd.op = OP_CDE; end
         ST_CDE_W: begin cmd.wr  = 1'b1; cmd.op = OP_CDE; end
         ST_QS_M:  begin cmd.mul = 1'b1; cmd.op = OP_QS;  end
         ST_QS_W:  begin cmd.wr  = 1'b1; cmd.op = OP_QS;  end
         ST_G_M:   begin cmd.mul = 1'b1; cmd.op = OP_G;   end
         ST_G_W:   begin cmd.wr  = 1'b1; cmd.op = OP_G;   end
         ST_H_M:   begin cmd.mul = 1'b1; cmd.op = OP_H;   end
         ST_H_W:   begin cmd.commit = out_free; cmd.op = OP_H; end
         ST_CLEAR: cmd.clear = out_free;
         default:  cmd.op = OP_DE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit || cmd.clear) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_H_W || $past(state_ff) == ST_CLEAR))
      else $error("result word raised outside a final state");

   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && !req_action) |=> (state_ff == ST_DE_M))
      else $error("control step did not start after acceptance");

   a_commit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_H_W && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_H_W))
      else $error("commit went ahead while the result word was still held");
`endif

endmodule

`default_nettype wire

@@ rtl/smsc_dp.sv @@
`default_nettype none

module smsc_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire smsc_pkg::cmd_type               cmd,
   input  wire smsc_pkg::cfg_type               cfg,
   input  wire logic signed [smsc_pkg::DATA_W-1:0] reference,
   input  wire logic signed [smsc_pkg::DATA_W-1:0] feedback,
   output logic signed [smsc_pkg::DATA_W-1:0]   drive_out,
   output logic                                 frozen_out
);
   import smsc_pkg::*;

   logic signed [DATA_W-1:0] e_ff, de_ff, s_ff, mcde_ff, brk_ff, drive_ff;
   logic signed [DATA_W-1:0] prev_error_ff, prev_drive_ff, integ_ff;
   logic signed [DATA_W-1:0] prev_error_in, prev_drive_in, integ_in;
   logic                     frozen_ff, frozen_in;
   logic [PROD_W-1:0]        prod_ff;
   logic                     neg_ff;
   logic signed [DATA_W-1:0] out_drive_ff;
   logic                     out_frozen_ff;

   logic signed [DATA_W:0]   a_op;
   logic [CFG_W-1:0]         b_op;
   logic [DATA_W:0]          a_mag;
   logic [PROD_W-1:0]        prod_in;
   logic signed [DATA_W-1:0] mres;
   logic signed [SUM_W-1:0]  err_sum, s_sum, brk_sum, sw_term;
   logic signed [DATA_W:0]   v_sum, max_x, min_x;
   logic                     opposed, in_band;

   assign drive_out  = out_drive_ff;
   assign frozen_out = out_frozen_ff;

   assign err_sum = sext_sum(reference) - sext_sum(feedback);

   always_comb begin
      unique case (cmd.op)
         OP_DE: begin
            a_op = {e_ff[DATA_W-1], e_ff} - {prev_error_ff[DATA_W-1], prev_error_ff};
            b_op = cfg.inv_period;
         end
         OP_CE: begin
            a_op = {e_ff[DATA_W-1], e_ff};
            b_op = cfg.surface_slope;
         end
         OP_CDE: begin
            a_op = {de_ff[DATA_W-1], de_ff};
            b_op = cfg.surface_slope;
         end
         OP_QS: begin
            a_op = {s_ff[DATA_W-1], s_ff};
            b_op = cfg.exp_gain;
         end
         OP_G: begin
            a_op = {brk_ff[DATA_W-1], brk_ff};
            b_op = cfg.overall_gain;
         end
         OP_H: begin
            a_op = {drive_ff[DATA_W-1], drive_ff} + {prev_drive_ff[DATA_W-1], prev_drive_ff};
            b_op = cfg.half_period;
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
      a_mag   = a_op[DATA_W] ? -a_op : a_op;
      prod_in = PROD_W'(a_mag) * PROD_W'(b_op);
   end

   assign mres = scale_product(prod_ff, neg_ff, cmd.op == OP_H);

   always_comb begin
      if (s_ff > 0) begin
         sw_term = {{(SUM_W-CFG_W){1'b0}}, cfg.switch_gain};
      end else if (s_ff < 0) begin
         sw_term = -{{(SUM_W-CFG_W){1'b0}}, cfg.switch_gain};
      end else begin
         sw_term = '0;
      end
      s_sum   = sext_sum(mres) + sext_sum(de_ff);
      brk_sum = sw_term + sext_sum(mres) + sext_sum(mcde_ff);
   end

   always_comb begin
      max_x   = {cfg.out_max[DATA_W-1], cfg.out_max};
      min_x   = {cfg.out_min[DATA_W-1], cfg.out_min};
      v_sum   = {integ_ff[DATA_W-1], integ_ff} + {mres[DATA_W-1], mres};
      opposed = (drive_ff < 0 && integ_ff > 0) || (drive_ff > 0 && integ_ff < 0);
      in_band = (integ_ff < cfg.out_max) && (integ_ff > cfg.out_min);

      integ_in      = integ_ff;
      frozen_in     = frozen_ff;
      prev_error_in = prev_error_ff;
      prev_drive_in = prev_drive_ff;
      if (cmd.clear) begin
         integ_in      = '0;
         frozen_in     = 1'b0;
         prev_error_in = '0;
         prev_drive_in = '0;
      end else if (cmd.commit) begin
         prev_error_in = e_ff;
         prev_drive_in = drive_ff;
         if (frozen_ff) begin
            frozen_in = !(opposed || in_band);
         end else begin
            priority if (v_sum > max_x) begin
               integ_in  = cfg.out_max;
               frozen_in = 1'b1;
            end else if (v_sum < min_x) begin
               integ_in  = cfg.out_min;
               frozen_in = 1'b1;
            end else begin
               integ_in  = v_sum[DATA_W-1:0];
               frozen_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff      <= '0;
         frozen_ff     <= 1'b0;
         prev_error_ff <= '0;
         prev_drive_ff <= '0;
      end else begin
         integ_ff      <= integ_in;
         frozen_ff     <= frozen_in;
         prev_error_ff <= prev_error_in;
         prev_drive_ff <= prev_drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         e_ff <= sat_data(err_sum);
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         neg_ff  <= a_op[DATA_W];
      end
      if (cmd.wr) begin
         unique case (cmd.op)
            OP_DE:   de_ff   <= mres;
            OP_CE:   s_ff    <= sat_data(s_sum);
            OP_CDE:  mcde_ff <= mres;
            OP_QS:   brk_ff  <= sat_data(brk_sum);
            OP_G:    drive_ff <= mres;
            default: drive_ff <= drive_ff;
         endcase
      end
      if (cmd.commit || cmd.clear) begin
         out_drive_ff  <= integ_in;
         out_frozen_ff <= frozen_in;
      end
   end

`ifndef ASSERT_OFF
   a_freeze_at_limit: assert property (@(posedge clock) disable iff (reset)
      $rose(frozen_ff) |-> (integ_ff == cfg.out_max || integ_ff == cfg.out_min))
      else $error("integration froze away from a limit");

   a_word_matches_state: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.commit) || $past(cmd.clear)) |->
         (out_drive_ff == integ_ff && out_frozen_ff == frozen_ff))
      else $error("result word differs from the integrator state");

   a_frozen_holds: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.commit) && $past(frozen_ff)) |-> (integ_ff == $past(integ_ff)))
      else $error("integrator moved while frozen");
`endif

endmodule

`default_nettype wire

@@ rtl/sliding_mode_speed_controller.sv @@
// Control step: the result word is registered at the final commit of an accepted request.
// A new request is accepted only once the step is through; the step runs on
// the single shared multiplier forming six products, each a multiply and a scale state.
// A held result word stalls only the final commit or a clear request.
// Synchronous active-high reset zeroes the controller state and loads the register defaults.
`default_nettype none

module sliding_mode_speed_controller (
   input  wire logic clock,
   input  wire logic reset,
   smsc_req_if.sink    req_ch,
   smsc_rsp_if.source  rsp_ch,
   smsc_csr_if.sink    csr_ch
);
   import smsc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   smsc_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   smsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .cmd        (cmd)
   );

   smsc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .reference  (req_ch.reference),
      .feedback   (req_ch.feedback),
      .drive_out  (rsp_ch.drive_out),
      .frozen_out (rsp_ch.frozen_out)
   );

endmodule

`default_nettype wire
